// ===== design/ascii_integer_parser_top_defines.svh =====
// Assertion macros shared by the parser RTL.
// Each macro uses the clk and rst_n signals of the module that expands it.
`ifndef ASCII_INTEGER_PARSER_TOP_DEFINES_SVH
`define ASCII_INTEGER_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define AIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold at the following clock edge.
`define AIP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`else

`define AIP_ASSERT(label, prop, msg)
`define AIP_ASSERT_NEXT(label, cond, cons, msg)

`endif

`endif

// ===== design/aip_pkg.sv =====
`timescale 1ns / 1ps

package aip_pkg;

    localparam int unsigned ACC_W  = 63;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned VAL_W  = 64;
    localparam int unsigned PROD_W = ACC_W + 5;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_REST   = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    // Decodes one character as a digit of the given radix.
    function automatic digit_t decode_digit(input logic [CHAR_W-1:0] c, input logic hex);
        digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - CHAR_ZERO);
        end
        else if (hex && c >= CHAR_LA && c <= CHAR_LF)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - CHAR_LA + 8'd10);
        end
        else if (hex && c >= CHAR_UA && c <= CHAR_UF)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - CHAR_UA + 8'd10);
        end
        return d;
    endfunction

endpackage

// ===== design/ascii_integer_parser_top.sv =====
`timescale 1ns / 1ps
// Streaming ASCII-to-integer parser. Each input item carries one character,
// and tlast marks the final character of a string. A string may begin with
// '+' or '-' and is read as decimal, or, when it begins with "0x" or "0X"
// and more characters follow, as hex, which takes no sign. On the final
// character the block emits one item: the signed 64-bit value in tdata and
// an ok flag in tuser; ok is low, and the value zero, for a bad character,
// a string with no digits, or a magnitude above the largest signed 64-bit
// value. The block takes one character per cycle unless a final character
// waits for an untaken result to leave; an input register feeds the digit
// step (one shift-and-add by ten or sixteen plus an overflow check), which
// updates the parser state and loads the result register directly.
`include "ascii_integer_parser_top_defines.svh"

module ascii_integer_parser_top
    import aip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] char_in
    input  logic              s_axis_tlast,   // is_last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [VAL_W-1:0]  m_axis_tdata,   // [63:0] value
    output logic              m_axis_tuser    // [0] ok
);

    localparam logic [PROD_W-1:0] MAX_MAG = {5'd0, {ACC_W{1'b1}}};

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [1:0]        position_reg, position_next;
    logic              neg_reg, neg_next;
    logic              fwz_reg, fwz_next;
    logic              hex_reg, hex_next;
    logic              seen_reg, seen_next;
    logic              failed_reg, failed_next;

    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    logic              out_ok_reg, out_ok_next;

    logic              advance;
    logic              take;
    logic              use_hex;
    digit_t            dig;
    logic [PROD_W-1:0] prod;
    logic              good;
    logic [VAL_W-1:0]  mag;

    // A final character needs room in the result register; others never wait.
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_ok_reg;

    always_comb
    begin
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        fwz_next      = fwz_reg;
        hex_next      = hex_reg;
        seen_next     = seen_reg;
        failed_next   = failed_reg;
        position_next = (position_reg == POS_REST) ? POS_REST : position_reg + 2'd1;
        take          = 1'b0;
        use_hex       = 1'b0;

        if (!failed_reg)
        begin
            if (position_reg == POS_FIRST)
            begin
                fwz_next = (in_char_reg == CHAR_ZERO);
                if (in_char_reg == CHAR_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else if (in_char_reg != CHAR_PLUS)
                begin
                    take = 1'b1;
                end
            end
            else if (position_reg == POS_SECOND && fwz_reg && !in_last_reg &&
                     (in_char_reg == CHAR_LX || in_char_reg == CHAR_UX))
            begin
                hex_next = 1'b1;
            end
            else
            begin
                take    = 1'b1;
                use_hex = hex_reg;
            end
        end

        dig = decode_digit(in_char_reg, use_hex);
        if (use_hex)
            prod = {1'b0, acc_reg, 4'd0} + PROD_W'(dig.value);
        else
            prod = {2'd0, acc_reg, 3'd0} + {4'd0, acc_reg, 1'b0} + PROD_W'(dig.value);

        if (take)
        begin
            if (!dig.valid || prod > MAX_MAG)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                acc_next  = prod[ACC_W-1:0];
                seen_next = 1'b1;
            end
        end

        good = !failed_next && seen_next;
        mag  = {1'b0, acc_next};
        if (!good)
            out_value_next = '0;
        else if (neg_next && !hex_next)
            out_value_next = VAL_W'(0) - mag;
        else
            out_value_next = mag;
        out_ok_next = good;

        if (in_last_reg)
        begin
            acc_next      = '0;
            position_next = POS_FIRST;
            neg_next      = 1'b0;
            fwz_next      = 1'b0;
            hex_next      = 1'b0;
            seen_next     = 1'b0;
            failed_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            position_reg  <= POS_FIRST;
            neg_reg       <= 1'b0;
            fwz_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;

            if (advance)
            begin
                acc_reg      <= acc_next;
                position_reg <= position_next;
                neg_reg      <= neg_next;
                fwz_reg      <= fwz_next;
                hex_reg      <= hex_next;
                seen_reg     <= seen_next;
                failed_reg   <= failed_next;
            end

            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_value_reg <= out_value_next;
            out_ok_reg    <= out_ok_next;
        end
    end

    `AIP_ASSERT(a_pos_range, position_reg != 2'd3, "position left its saturating range")
    `AIP_ASSERT_NEXT(a_clear_after_last, advance && in_last_reg,
        position_reg == POS_FIRST && !failed_reg && !seen_reg && acc_reg == '0,
        "parser state not cleared after the final character")
    `AIP_ASSERT_NEXT(a_failed_holds_acc, failed_reg && !(advance && in_last_reg),
        $stable(acc_reg), "accumulator changed after a failure")
    `AIP_ASSERT(a_fail_value_zero, !(out_valid_reg && !out_ok_reg) || out_value_reg == '0,
        "failed result carries a nonzero value")
    `AIP_ASSERT_NEXT(a_result_source, !out_valid_reg && !(advance && in_last_reg),
        !out_valid_reg, "result appeared without a final character")

endmodule
